// ===== rtl/mrcms_pkg.sv =====
// shared constants and types for the matrix row/column sum maximum unit
package mrcms_pkg;

    // configuration port
    localparam int CFG_W  = 7;
    localparam int CFG_AW = 1;

    localparam logic [CFG_AW-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_NUM_COLS = 1'b1;

    // column store access request
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_col_ctl;

endpackage

// ===== rtl/mrcms_elem_if.sv =====
// element stream channel
interface mrcms_elem_if #(
    parameter int ELEM_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [ELEM_BITS-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

// ===== rtl/mrcms_res_if.sv =====
// result channel
interface mrcms_res_if #(
    parameter int RI_W  = 6,
    parameter int CI_W  = 6,
    parameter int SUM_W = 22
);
    logic                    valid;
    logic                    ready;
    logic [RI_W-1:0]         best_row;
    logic signed [SUM_W-1:0] best_row_sum;
    logic [CI_W-1:0]         best_col;
    logic signed [SUM_W-1:0] best_col_sum;

    modport source (
        output valid, output best_row, output best_row_sum,
        output best_col, output best_col_sum, input ready
    );
    modport sink (
        input valid, input best_row, input best_row_sum,
        input best_col, input best_col_sum, output ready
    );
endinterface

// ===== rtl/mrcms_col_bank.sv =====
// column sum store, one write and one registered read per cycle
module mrcms_col_bank #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 22
) (
    input  logic                  i_clk,
    input  mrcms_pkg::t_col_ctl   i_ctl,
    input  logic [AW-1:0]         i_addr,
    input  logic signed [DW-1:0]  i_wdata,
    output logic signed [DW-1:0]  o_rdata
);
    import mrcms_pkg::*;

    logic signed [DW-1:0] r_mem [DEPTH];
    logic signed [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/matrix_row_col_max_sum_unit.sv =====
// top level: streaming matrix row and column sum maximum finder
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+--------------------------------------------
//  i_elem    | in  | valid / ready      | element (signed, ELEM_BITS)
//  o_res     | out | valid / ready      | best_row, best_row_sum, best_col, best_col_sum
//  i_cfg_*   | in  | write enable only  | register index, 7-bit data
//
//  an element passes accept, column add and row add, the two adds on the one shared adder
//  the last element of a row adds a row compare step on the shared comparator
//  the last element of the matrix adds the column scan, which makes one
//  store read and one compare per column, then the result is loaded into the output register
//  reset is synchronous; the column store is not cleared, row 0 of every matrix rewrites it
//  elements are accepted while a result waits; a finished matrix holds until o_res is free
module matrix_row_col_max_sum_unit #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int ELEM_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [mrcms_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [mrcms_pkg::CFG_W-1:0]  i_cfg_data,
    // element stream
    mrcms_elem_if.sink                   i_elem,
    // result stream
    mrcms_res_if.source                  o_res
);
    import mrcms_pkg::*;

    // widths
    localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CI_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int GROW_W = (RI_W > CI_W) ? RI_W : CI_W;
    localparam int SUM_W  = ELEM_BITS + GROW_W;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_COL_ADD  = 3'd1;
    localparam logic [2:0] S_ROW_ADD  = 3'd2;
    localparam logic [2:0] S_ROW_END  = 3'd3;
    localparam logic [2:0] S_SCAN_RD  = 3'd4;
    localparam logic [2:0] S_SCAN_CMP = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]              r_state, n_state;

    // configuration
    logic [CFG_W-1:0]        r_num_rows;
    logic [CFG_W-1:0]        r_num_cols;
    logic [RCNT_W-1:0]       w_rows;
    logic [CCNT_W-1:0]       w_cols;

    // matrix walk state
    logic signed [ELEM_BITS-1:0] r_elem;
    logic [RI_W-1:0]         r_row_pos;
    logic [CI_W-1:0]         r_col_pos;
    logic signed [SUM_W-1:0] r_row_acc;
    logic [RI_W-1:0]         r_top_idx;
    logic signed [SUM_W-1:0] r_top_total;

    // column scan
    logic [CI_W-1:0]         r_scan_idx;
    logic [CI_W-1:0]         r_best_col;
    logic signed [SUM_W-1:0] r_best_cs;

    // output register
    logic                    r_out_vld;
    logic [RI_W-1:0]         r_out_row;
    logic signed [SUM_W-1:0] r_out_row_sum;
    logic [CI_W-1:0]         r_out_col;
    logic signed [SUM_W-1:0] r_out_col_sum;

    // shared adder and comparator
    logic signed [SUM_W-1:0] w_add_a;
    logic signed [SUM_W-1:0] w_add_sum;
    logic signed [SUM_W-1:0] w_cmp_a;
    logic signed [SUM_W-1:0] w_cmp_b;
    logic                    w_cmp_gt;

    // column store
    t_col_ctl                w_col_ctl;
    logic [CI_W-1:0]         w_col_addr;
    logic signed [SUM_W-1:0] w_col_rdata;

    logic                    w_accept;
    logic                    w_row_last;
    logic                    w_mat_last;
    logic                    w_scan_last;
    logic                    w_out_free;

    // size clamps: zero counts as one, anything above the maximum as the maximum
    always_comb begin
        if (r_num_rows == '0) begin
            w_rows = RCNT_W'(1);
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            w_rows = RCNT_W'(MAX_ROWS);
        end else begin
            w_rows = RCNT_W'(r_num_rows);
        end
        if (r_num_cols == '0) begin
            w_cols = CCNT_W'(1);
        end else if (32'(r_num_cols) > MAX_COLS) begin
            w_cols = CCNT_W'(MAX_COLS);
        end else begin
            w_cols = CCNT_W'(r_num_cols);
        end
    end

    // end-of-row / end-of-matrix / end-of-scan tests (reach or pass the count)
    assign w_row_last  = !((CCNT_W'(r_col_pos) + CCNT_W'(1)) < w_cols);
    assign w_mat_last  = !((RCNT_W'(r_row_pos) + RCNT_W'(1)) < w_rows);
    assign w_scan_last = !((CCNT_W'(r_scan_idx) + CCNT_W'(1)) < w_cols);

    assign w_accept    = i_elem.valid && i_elem.ready;
    assign w_out_free  = !r_out_vld || o_res.ready;

    // shared adder: column total in one step, row total in the next
    always_comb begin
        if (r_state == S_COL_ADD) begin
            w_add_a = (r_row_pos == '0) ? '0 : w_col_rdata;
        end else begin
            w_add_a = (r_col_pos == '0) ? '0 : r_row_acc;
        end
    end
    assign w_add_sum = w_add_a + SUM_W'(r_elem);

    // shared comparator: row total against best row, or column total against best column
    always_comb begin
        if (r_state == S_SCAN_CMP) begin
            w_cmp_a = w_col_rdata;
            w_cmp_b = r_best_cs;
        end else begin
            w_cmp_a = r_row_acc;
            w_cmp_b = r_top_total;
        end
    end
    assign w_cmp_gt = w_cmp_a > w_cmp_b;

    // column store access
    always_comb begin
        w_col_ctl.wr_en = (r_state == S_COL_ADD);
        w_col_ctl.rd_en = w_accept || (r_state == S_SCAN_RD);
        w_col_addr      = (r_state == S_SCAN_RD) ? r_scan_idx : r_col_pos;
    end

    mrcms_col_bank #(
        .DEPTH (MAX_COLS),
        .AW    (CI_W),
        .DW    (SUM_W)
    ) u_col_bank (
        .i_clk   (i_clk),
        .i_ctl   (w_col_ctl),
        .i_addr  (w_col_addr),
        .i_wdata (w_add_sum),
        .o_rdata (w_col_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_COL_ADD;
                end
            end
            S_COL_ADD: begin
                n_state = S_ROW_ADD;
            end
            S_ROW_ADD: begin
                n_state = w_row_last ? S_ROW_END : S_IDLE;
            end
            S_ROW_END: begin
                n_state = w_mat_last ? S_SCAN_RD : S_IDLE;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                n_state = w_scan_last ? S_DONE : S_SCAN_RD;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_num_rows <= CFG_W'(1);
            r_num_cols <= CFG_W'(1);
            r_row_pos  <= '0;
            r_col_pos  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                    CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_ROW_ADD && !w_row_last) begin
                r_col_pos <= r_col_pos + CI_W'(1);
            end
            if (r_state == S_ROW_END) begin
                r_col_pos <= '0;
                r_row_pos <= w_mat_last ? '0 : r_row_pos + RI_W'(1);
            end

            if (r_state == S_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_elem <= i_elem.element;
        end
        if (r_state == S_ROW_ADD) begin
            r_row_acc <= w_add_sum;
        end
        if (r_state == S_ROW_END) begin
            // first row always wins, later rows only on a strictly greater sum
            if (r_row_pos == '0 || w_cmp_gt) begin
                r_top_idx   <= r_row_pos;
                r_top_total <= r_row_acc;
            end
            r_scan_idx <= '0;
        end
        if (r_state == S_SCAN_CMP) begin
            if (r_scan_idx == '0 || w_cmp_gt) begin
                r_best_col <= r_scan_idx;
                r_best_cs  <= w_col_rdata;
            end
            r_scan_idx <= r_scan_idx + CI_W'(1);
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_row     <= r_top_idx;
            r_out_row_sum <= r_top_total;
            r_out_col     <= r_best_col;
            r_out_col_sum <= r_best_cs;
        end
    end

    assign i_elem.ready       = (r_state == S_IDLE);
    assign o_res.valid        = r_out_vld;
    assign o_res.best_row     = r_out_row;
    assign o_res.best_row_sum = r_out_row_sum;
    assign o_res.best_col     = r_out_col;
    assign o_res.best_col_sum = r_out_col_sum;

`ifndef ASSERT_OFF
    // an accepted element always goes to the column add next
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_COL_ADD)
        else $error("accepted element did not start column add");

    // a new result appears only out of the done state
    a_res_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");

    // the column store is written only by the column add step
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_col_ctl.wr_en |-> !w_col_ctl.rd_en && r_state == S_COL_ADD)
        else $error("column store written outside column add");

    // a finished matrix waits while the previous result is still held
    a_done_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_vld && !o_res.ready) |=> r_state == S_DONE)
        else $error("result overwritten while still pending");
`endif

endmodule
